### hdl/double_round_abs_minmax_unit_macros.svh
// Assertion macros used by the double round/abs/min/max unit.
// No dependencies.
`ifndef DOUBLE_ROUND_ABS_MINMAX_UNIT_MACROS_SVH
`define DOUBLE_ROUND_ABS_MINMAX_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define DRAM_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define DRAM_ASSERT_NXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

### hdl/dram_pkg.sv
// Shared types, opcodes and constants for the double round/abs/min/max unit.
// No dependencies.
`default_nettype none
package dram_pkg;
   typedef enum logic [2:0] {
      OP_ABS   = 3'd0,
      OP_TRUNC = 3'd1,
      OP_FLOOR = 3'd2,
      OP_CEIL  = 3'd3,
      OP_MAX   = 3'd4,
      OP_MIN   = 3'd5,
      OP_BAD6  = 3'd6,
      OP_BAD7  = 3'd7
   } op_type;

   localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
   localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
   localparam logic [10:0] EXP_ALL   = 11'h7FF;
   localparam logic [10:0] EXP_BIAS  = 11'd1023;
   localparam logic [10:0] EXP_INT   = 11'd1075;

   // Result kind chosen in stage 1, resolved in stage 3.
   typedef enum logic [2:0] {
      K_PASS  = 3'd0,   // value is final
      K_MASK  = 3'd1,   // clear low fraction bits, maybe add unit
      K_MINMAX= 3'd2,   // pick by ordered-key compare
      K_ZERO  = 3'd3    // invalid opcode
   } kind_type;

   // Stage 1 -> stage 2 word.
   typedef struct packed {
      kind_type    kind;
      logic        away;
      logic        pick_max;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] low;      // mask of fraction bits below the unit
      logic [63:0] key_a;
      logic [63:0] key_b;
      logic        bad;
   } s1_type;

   // Stage 2 -> stage 3 word.
   typedef struct packed {
      logic        add_unit;
      logic        a_big;
      kind_type    kind;
      logic        pick_max;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] trunc;
      logic [63:0] unit;
      logic        bad;
   } s2_type;

   function automatic logic is_nan(input logic [63:0] x);
      is_nan = (x[62:52] == EXP_ALL) && (x[51:0] != 52'd0);
   endfunction

   function automatic logic [63:0] order_key(input logic [63:0] x);
      order_key = x[63] ? ~x : (x | SIGN_BIT);
   endfunction
endpackage
`default_nettype wire

### hdl/double_round_abs_minmax_unit.sv
// Top level of the binary64 abs/trunc/floor/ceil/max/min unit.
// Uses dram_pkg, dram_decode, dram_compare, dram_finish.
//
//  channel | ports                                  | dir
//  req     | req_valid req_ready req_operation/a/b  | in
//  rsp     | rsp_valid rsp_ready rsp_result_bits/bad| out
//
// Three register stages: decode, mask/compare, increment/select.
// Throughput one word per cycle while the output is not stalled.
// The whole pipe advances together when the output stage is empty or taken.
// A stall freezes every stage; bubbles do not advance out on their own slot.
// Synchronous reset clears the valid bits only.
`default_nettype none
module double_round_abs_minmax_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_operation,
   input  wire logic [63:0] req_operand_a,
   input  wire logic [63:0] req_operand_b,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_result_bits,
   output logic             rsp_bad_operation
);
   logic adv;
   logic v1, v2;
   dram_pkg::s1_type d1;
   dram_pkg::s2_type d2;

   // advance when the last stage is free or being drained
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   dram_decode u_decode (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(req_valid),
      .operation(req_operation), .operand_a(req_operand_a), .operand_b(req_operand_b),
      .valid_ff(v1), .data_ff(d1));

   dram_compare u_compare (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(v1), .in_data(d1),
      .valid_ff(v2), .data_ff(d2));

   dram_finish u_finish (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(v2), .in_data(d2),
      .valid_ff(rsp_valid), .result_ff(rsp_result_bits), .bad_ff(rsp_bad_operation));
endmodule
`default_nettype wire

### hdl/dram_decode.sv
// Stage 1: opcode decode, special cases, fraction mask and ordered keys.
// Uses dram_pkg.
`default_nettype none
module dram_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire logic [2:0]        operation,
   input  wire logic [63:0]       operand_a,
   input  wire logic [63:0]       operand_b,
   output logic                   valid_ff,
   output dram_pkg::s1_type       data_ff
);
   dram_pkg::s1_type data_in;
   logic [10:0] e;
   logic [5:0]  fb;
   logic        away;
   logic        nan_any;

   always_comb begin
      e       = operand_a[62:52];
      fb      = 6'(dram_pkg::EXP_INT - e);
      away    = (dram_pkg::op_type'(operation) == dram_pkg::OP_FLOOR && operand_a[63])
             || (dram_pkg::op_type'(operation) == dram_pkg::OP_CEIL && !operand_a[63]);
      nan_any = dram_pkg::is_nan(operand_a) || dram_pkg::is_nan(operand_b);
      data_in          = '0;
      data_in.a        = operand_a;
      data_in.b        = operand_b;
      data_in.away     = away;
      data_in.low      = (64'd1 << fb) - 64'd1;
      data_in.key_a    = dram_pkg::order_key(operand_a);
      data_in.key_b    = dram_pkg::order_key(operand_b);
      data_in.pick_max = dram_pkg::op_type'(operation) == dram_pkg::OP_MAX;
      data_in.kind     = dram_pkg::K_PASS;
      unique case (dram_pkg::op_type'(operation))
         dram_pkg::OP_ABS: begin
            data_in.a = operand_a & ~dram_pkg::SIGN_BIT;
         end
         dram_pkg::OP_TRUNC, dram_pkg::OP_FLOOR, dram_pkg::OP_CEIL: begin
            if (e == dram_pkg::EXP_ALL) begin
               if (operand_a[51:0] != 52'd0) data_in.a = operand_a | dram_pkg::QUIET_BIT;
            end else if (operand_a[62:0] == 63'd0 || e >= dram_pkg::EXP_INT) begin
               data_in.a = operand_a;
            end else if (e < dram_pkg::EXP_BIAS) begin
               data_in.a = away ? ({operand_a[63], 63'd0} | dram_pkg::ONE_BITS)
                                : {operand_a[63], 63'd0};
            end else begin
               data_in.kind = dram_pkg::K_MASK;
            end
         end
         dram_pkg::OP_MAX, dram_pkg::OP_MIN: begin
            if (nan_any) data_in.a = dram_pkg::CANON_NAN;
            else data_in.kind = dram_pkg::K_MINMAX;
         end
         default: begin
            data_in.kind = dram_pkg::K_ZERO;
            data_in.bad  = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= in_valid;
      if (adv) data_ff <= data_in;
   end
endmodule
`default_nettype wire

### hdl/dram_compare.sv
// Stage 2: masked truncation and 64-bit key compare.
// Uses dram_pkg.
`default_nettype none
module dram_compare (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire dram_pkg::s1_type  in_data,
   output logic                   valid_ff,
   output dram_pkg::s2_type       data_ff
);
   dram_pkg::s2_type data_in;

   always_comb begin
      data_in.kind     = in_data.kind;
      data_in.pick_max = in_data.pick_max;
      data_in.a        = in_data.a;
      data_in.b        = in_data.b;
      data_in.bad      = in_data.bad;
      data_in.trunc    = in_data.a & ~in_data.low;
      data_in.unit     = in_data.low + 64'd1;
      data_in.add_unit = in_data.away && ((in_data.a & in_data.low) != 64'd0);
      data_in.a_big    = in_data.key_a >= in_data.key_b;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= in_valid;
      if (adv) data_ff <= data_in;
   end
endmodule
`default_nettype wire

### hdl/dram_finish.sv
// Stage 3: increment, selection and result register.
// Uses dram_pkg and the assertion macro header.
`default_nettype none
`include "double_round_abs_minmax_unit_macros.svh"
module dram_finish (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire dram_pkg::s2_type  in_data,
   output logic                   valid_ff,
   output logic [63:0]            result_ff,
   output logic                   bad_ff
);
   logic [63:0] result_in;

   always_comb begin
      unique case (in_data.kind)
         dram_pkg::K_MASK:
            result_in = in_data.add_unit ? in_data.trunc + in_data.unit : in_data.trunc;
         dram_pkg::K_MINMAX:
            result_in = (in_data.a_big == in_data.pick_max) ? in_data.a : in_data.b;
         dram_pkg::K_ZERO: result_in = 64'd0;
         default:          result_in = in_data.a;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= in_valid;
      if (adv) begin
         result_ff <= result_in;
         bad_ff    <= in_data.bad;
      end
   end

   `DRAM_ASSERT_IMP(a_bad_zero, clock, reset, valid_ff && bad_ff, result_ff == 64'd0,
      "bad opcode word carries nonzero result")
   `DRAM_ASSERT_NXT(a_hold, clock, reset, valid_ff && !adv,
      valid_ff && $stable(result_ff) && $stable(bad_ff), "stalled word changed")
   `DRAM_ASSERT_NXT(a_zero_kind, clock, reset, adv && in_valid && in_data.kind == dram_pkg::K_ZERO,
      bad_ff, "invalid kind lost its error flag")
endmodule
`default_nettype wire

### dv/tb.sv
// Regression bench for the binary64 abs/trunc/floor/ceil/max/min unit.
// Depends on dram_pkg and double_round_abs_minmax_unit; self-contained otherwise.
`default_nettype none
module tb;
   localparam logic [63:0] EXP_FIELD = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] FRAC_FIELD = 64'h000F_FFFF_FFFF_FFFF;
   localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_operation = '0;
   logic [63:0] req_operand_a = '0;
   logic [63:0] req_operand_b = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_result_bits;
   logic        rsp_bad_operation;

   // Expected words, oldest first.
   logic [63:0] want_bits[$];
   logic        want_bad[$];
   int unsigned errors = 0;
   int unsigned cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   double_round_abs_minmax_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_bits(rsp_result_bits), .rsp_bad_operation(rsp_bad_operation)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic nan_bits(input logic [63:0] x);
      return ((x & EXP_FIELD) == EXP_FIELD) && ((x & FRAC_FIELD) != 64'd0);
   endfunction

   // Ordered key: negatives reversed below positives, -0 just under +0.
   function automatic logic [63:0] rank_key(input logic [63:0] x);
      return x[63] ? ~x : (x | dram_pkg::SIGN_BIT);
   endfunction

   // Integer rounding on the raw pattern.
   function automatic logic [63:0] round_to_int(input logic [63:0] x,
                                                input dram_pkg::op_type op);
      logic [10:0] ex;
      logic        up;
      logic [63:0] step;
      logic [63:0] frac_low;
      ex = x[62:52];
      up = (op == dram_pkg::OP_FLOOR && x[63]) || (op == dram_pkg::OP_CEIL && !x[63]);
      if (ex == dram_pkg::EXP_ALL) return (x[51:0] != 52'd0) ? (x | dram_pkg::QUIET_BIT) : x;
      if (x[62:0] == 63'd0 || ex >= dram_pkg::EXP_INT) return x;
      // Below one in magnitude: signed zero or signed one.
      if (ex < dram_pkg::EXP_BIAS)
         return up ? ((x & dram_pkg::SIGN_BIT) | dram_pkg::ONE_BITS) : (x & dram_pkg::SIGN_BIT);
      step = 64'd1 << (dram_pkg::EXP_INT - ex);
      frac_low = step - 64'd1;
      if ((x & frac_low) == 64'd0) return x;
      return up ? ((x & ~frac_low) + step) : (x & ~frac_low);
   endfunction

   task automatic math_result(input dram_pkg::op_type op, input logic [63:0] a,
                              input logic [63:0] b,
                              output logic [63:0] r, output logic bad);
      logic a_big;
      bad = 1'b0;
      r = '0;
      case (op)
         dram_pkg::OP_ABS: r = a & ~dram_pkg::SIGN_BIT;
         dram_pkg::OP_TRUNC, dram_pkg::OP_FLOOR, dram_pkg::OP_CEIL: r = round_to_int(a, op);
         dram_pkg::OP_MAX, dram_pkg::OP_MIN: begin
            if (nan_bits(a) || nan_bits(b)) begin
               r = dram_pkg::CANON_NAN;
            end else begin
               a_big = rank_key(a) >= rank_key(b);
               if (op == dram_pkg::OP_MAX) r = a_big ? a : b;
               else r = a_big ? b : a;
            end
         end
         default: bad = 1'b1;
      endcase
   endtask

   // Send one word; valid holds until accepted and drops only while idling.
   task automatic send_word(input dram_pkg::op_type op, input logic [63:0] a,
                            input logic [63:0] b);
      logic [63:0] r;
      logic        bad;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      math_result(op, a, b, r, bad);
      req_valid <= 1'b1;
      req_operation <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want_bits.push_back(r);
      want_bad.push_back(bad);
      @(negedge clock);
   endtask

   // Receiver stall pattern, updated on the falling edge.
   always @(negedge clock) begin
      if (!reset) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (want_bits.size() == 0) begin
            $display("%0t: unexpected word bits=%h bad=%b", $time,
                     rsp_result_bits, rsp_bad_operation);
            errors++;
         end else begin
            if (rsp_result_bits !== want_bits[0]) begin
               $display("%0t: result_bits expected %h actual %h", $time,
                        want_bits[0], rsp_result_bits);
               errors++;
            end
            if (rsp_bad_operation !== want_bad[0]) begin
               $display("%0t: bad_operation expected %b actual %b", $time,
                        want_bad[0], rsp_bad_operation);
               errors++;
            end
            void'(want_bits.pop_front());
            void'(want_bad.pop_front());
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("double_round_abs_minmax_unit regression: fail");
         $finish;
      end
   end

   // Random double biased toward rounding boundaries and specials.
   function automatic logic [63:0] pick_double();
      logic [63:0] x;
      int unsigned sel;
      x = {$urandom, $urandom};
      sel = $urandom_range(9);
      case (sel)
         0: x[62:52] = dram_pkg::EXP_ALL;
         1: x[62:52] = 11'd0;
         2: x[62:0] = 63'd0;
         3: x[51:0] = 52'd0;
         4: x[62:52] = dram_pkg::EXP_BIAS - 11'($urandom_range(3));
         5: x[51:0] = {52{1'b1}} << $urandom_range(51);
         default: x[62:52] = dram_pkg::EXP_BIAS + 11'($urandom_range(60));
      endcase
      return x;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (want_bits.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      logic [63:0] v[12];
      v = '{64'h0, NEG_ZERO, POS_INF, POS_INF | dram_pkg::SIGN_BIT, 64'h7FF0_0000_0000_0001,
            64'hFFF4_0000_0000_0000, 64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000,
            64'h3FFF_FFFF_FFFF_FFFF, 64'hC00C_0000_0000_0000, 64'h4330_0000_0000_0001,
            64'hFFFF_FFFF_FFFF_FFFF};
      for (int i = 0; i < 12; i++) begin
         send_word(dram_pkg::op_type'(i % 4), v[i], v[11 - i]);
      end
      send_word(dram_pkg::OP_MAX, 64'h0, NEG_ZERO);
      send_word(dram_pkg::OP_MIN, 64'h0, NEG_ZERO);
      send_word(dram_pkg::OP_MAX, NEG_ZERO, 64'h0);
      send_word(dram_pkg::OP_MIN, NEG_ZERO, 64'h0);
      send_word(dram_pkg::OP_MAX, 64'h7FF0_0000_0000_0001, 64'h0);
      send_word(dram_pkg::OP_MIN, 64'h0, 64'hFFF8_0000_0000_0000);
      send_word(dram_pkg::OP_MIN, POS_INF | dram_pkg::SIGN_BIT, POS_INF);
      send_word(dram_pkg::OP_BAD6, 64'h3FF0_0000_0000_0000, 64'h0);
      send_word(dram_pkg::OP_BAD7, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      wait_drained();
   endtask

   task automatic test_random(input int unsigned count, input int unsigned idle,
                              input int unsigned stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int unsigned i = 0; i < count; i++) begin
         send_word(dram_pkg::op_type'($urandom_range(7)), pick_double(), pick_double());
      end
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(400, 0, 0);
      test_random(350, 76, 0);
      test_random(350, 0, 76);
      test_random(400, 20, 20);
      repeat (20) @(posedge clock);
      if (errors == 0 && want_bits.size() == 0) begin
         $display("double_round_abs_minmax_unit regression: pass");
      end else begin
         $display("double_round_abs_minmax_unit regression: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire

### files.f
+incdir+hdl
hdl/dram_pkg.sv
hdl/dram_decode.sv
hdl/dram_compare.sv
hdl/dram_finish.sv
hdl/double_round_abs_minmax_unit.sv
dv/tb.sv
